FILE: sv/lprd_pkg.sv
package lprd_pkg;

    localparam int MAX_MESSAGE = 4096;
    localparam int MAX_ARGS    = 1024;

    localparam int MSG_W  = $clog2(MAX_MESSAGE + 1);
    localparam int ARGS_W = $clog2(MAX_ARGS + 1);
    localparam int ARGN_W = 10;

    localparam logic [2:0] KIND_FRAME   = 3'd0;
    localparam logic [2:0] KIND_COUNT   = 3'd1;
    localparam logic [2:0] KIND_LENGTH  = 3'd2;
    localparam logic [2:0] KIND_DATA    = 3'd3;
    localparam logic [2:0] KIND_SURPLUS = 3'd4;
    localparam logic [2:0] KIND_CLOSED  = 3'd5;

    localparam logic [2:0] ST_PROGRESS  = 3'd0;
    localparam logic [2:0] ST_OK        = 3'd1;
    localparam logic [2:0] ST_TOO_LONG  = 3'd2;
    localparam logic [2:0] ST_MALFORMED = 3'd3;
    localparam logic [2:0] ST_CLOSED    = 3'd4;

    typedef enum logic [2:0] {
        PH_FRAME,
        PH_COUNT,
        PH_LENGTH,
        PH_DATA,
        PH_SURPLUS
    } t_phase;

    typedef struct packed {
        t_phase              phase;
        logic [1:0]          field_byte_count;
        logic [31:0]         field_accumulator;
        logic [MSG_W-1:0]    message_bytes_left;
        logic [ARGS_W-1:0]   args_left;
        logic [MSG_W-1:0]    arg_bytes_left;
        logic [ARGN_W-1:0]   current_arg;
        logic                malformed;
        logic                closed;
    } t_state;

    typedef struct packed {
        logic [7:0]          byte_value;
        logic [2:0]          byte_kind;
        logic [ARGN_W-1:0]   arg_number;
        logic                arg_end;
        logic                message_end;
        logic [2:0]          status;
    } t_result;

endpackage

FILE: sv/lprd_in_if.sv
interface lprd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink (input valid, input stream_byte, output ready);
endinterface

FILE: sv/lprd_out_if.sv
interface lprd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic [2:0] byte_kind;
    logic [9:0] arg_number;
    logic       arg_end;
    logic       message_end;
    logic [2:0] status;

    modport source (
        output valid, output byte_value, output byte_kind, output arg_number,
        output arg_end, output message_end, output status, input ready
    );
    modport sink (
        input valid, input byte_value, input byte_kind, input arg_number,
        input arg_end, input message_end, input status, output ready
    );
endinterface

FILE: sv/lprd_in_reg.sv
module lprd_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lprd_in_if.sink       i_in,
    input  logic          i_take,
    output logic          o_valid,
    output logic [7:0]    o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign i_in.ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_byte     = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.stream_byte;
        end
    end

endmodule

FILE: sv/lprd_step.sv
module lprd_step
    import lprd_pkg::*;
(
    input  t_state       i_state,
    input  logic [7:0]   i_byte,
    output t_state       o_next,
    output t_result      o_result
);

    logic [31:0]       acc_base;
    logic [31:0]       acc_new;
    logic [1:0]        fbc_new;
    logic              field_done;
    logic [MSG_W-1:0]  mbl_dec;
    logic [MSG_W-1:0]  abl_dec;
    logic [ARGS_W-1:0] al_dec;

    always_comb begin
        acc_base   = (i_state.field_byte_count == 2'd0) ? 32'd0 : i_state.field_accumulator;
        acc_new    = acc_base | ({24'd0, i_byte} << {i_state.field_byte_count, 3'b000});
        fbc_new    = i_state.field_byte_count + 2'd1;
        field_done = (i_state.field_byte_count == 2'd3);
        mbl_dec    = (i_state.message_bytes_left != '0) ?
                     i_state.message_bytes_left - MSG_W'(1) : i_state.message_bytes_left;
        abl_dec    = (i_state.arg_bytes_left != '0) ?
                     i_state.arg_bytes_left - MSG_W'(1) : i_state.arg_bytes_left;
        al_dec     = (i_state.args_left != '0) ?
                     i_state.args_left - ARGS_W'(1) : i_state.args_left;
    end

    always_comb begin
        o_next                = i_state;
        o_result.byte_value   = i_byte;
        o_result.byte_kind    = KIND_FRAME;
        o_result.arg_number   = '0;
        o_result.arg_end      = 1'b0;
        o_result.message_end  = 1'b0;
        o_result.status       = ST_PROGRESS;

        if (i_state.closed) begin
            o_result.byte_kind = KIND_CLOSED;
            o_result.status    = ST_CLOSED;
        end else if (i_state.phase == PH_FRAME) begin
            o_next.field_byte_count  = fbc_new;
            o_next.field_accumulator = acc_new;
            if (field_done) begin
                if (acc_new > 32'(MAX_MESSAGE)) begin
                    o_result.status = ST_TOO_LONG;
                    o_next.closed   = 1'b1;
                end else if (acc_new == 32'd0) begin
                    o_result.status      = ST_MALFORMED;
                    o_result.message_end = 1'b1;
                    o_next.closed        = 1'b1;
                end else begin
                    o_next.message_bytes_left = acc_new[MSG_W-1:0];
                    o_next.malformed          = 1'b0;
                    o_next.args_left          = '0;
                    o_next.current_arg        = '0;
                    o_next.phase              = PH_COUNT;
                end
            end
        end else begin
            o_next.message_bytes_left = mbl_dec;
            case (i_state.phase)
                PH_COUNT: begin
                    o_result.byte_kind       = KIND_COUNT;
                    o_next.field_byte_count  = fbc_new;
                    o_next.field_accumulator = acc_new;
                    if (field_done) begin
                        if (acc_new > 32'(MAX_ARGS)) begin
                            o_next.malformed = 1'b1;
                            o_next.phase     = PH_SURPLUS;
                        end else begin
                            o_next.args_left   = acc_new[ARGS_W-1:0];
                            o_next.current_arg = '0;
                            o_next.phase       = (acc_new != 32'd0) ? PH_LENGTH : PH_SURPLUS;
                        end
                    end
                end
                PH_LENGTH: begin
                    o_result.byte_kind       = KIND_LENGTH;
                    o_result.arg_number      = i_state.current_arg;
                    o_next.field_byte_count  = fbc_new;
                    o_next.field_accumulator = acc_new;
                    if (field_done) begin
                        if (acc_new > 32'(mbl_dec)) begin
                            o_next.malformed = 1'b1;
                            o_next.phase     = PH_SURPLUS;
                        end else if (acc_new == 32'd0) begin
                            o_result.arg_end   = 1'b1;
                            o_next.args_left   = al_dec;
                            o_next.current_arg = i_state.current_arg + ARGN_W'(1);
                            o_next.phase       = (al_dec != '0) ? PH_LENGTH : PH_SURPLUS;
                        end else begin
                            o_next.arg_bytes_left = acc_new[MSG_W-1:0];
                            o_next.phase          = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    o_result.byte_kind    = KIND_DATA;
                    o_result.arg_number   = i_state.current_arg;
                    o_next.arg_bytes_left = abl_dec;
                    if (abl_dec == '0) begin
                        o_result.arg_end   = 1'b1;
                        o_next.args_left   = al_dec;
                        o_next.current_arg = i_state.current_arg + ARGN_W'(1);
                        o_next.phase       = (al_dec != '0) ? PH_LENGTH : PH_SURPLUS;
                    end
                end
                default: begin
                    o_result.byte_kind = KIND_SURPLUS;
                    o_next.malformed   = 1'b1;
                    o_next.phase       = PH_SURPLUS;
                end
            endcase

            if (mbl_dec == '0) begin
                o_result.message_end = 1'b1;
                if (o_next.malformed || o_next.phase != PH_SURPLUS) begin
                    o_result.status = ST_MALFORMED;
                    o_next.closed   = 1'b1;
                end else begin
                    o_result.status = ST_OK;
                end
                o_next.phase            = PH_FRAME;
                o_next.field_byte_count = 2'd0;
                o_next.malformed        = 1'b0;
                o_next.args_left        = '0;
                o_next.arg_bytes_left   = '0;
                o_next.current_arg      = '0;
            end
        end
    end

endmodule

FILE: sv/lprd_out_reg.sv
module lprd_out_reg
    import lprd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  t_result       i_result,
    output logic          o_free,
    lprd_out_if.source    o_out
);

    logic    r_valid;
    t_result r_result;

    assign o_free            = !r_valid || o_out.ready;
    assign o_out.valid       = r_valid;
    assign o_out.byte_value  = r_result.byte_value;
    assign o_out.byte_kind   = r_result.byte_kind;
    assign o_out.arg_number  = r_result.arg_number;
    assign o_out.arg_end     = r_result.arg_end;
    assign o_out.message_end = r_result.message_end;
    assign o_out.status      = r_result.status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

FILE: sv/length_prefixed_request_deframer.sv
// Request deframer for a length-prefixed byte stream.
// The input channel i_in carries one raw connection byte per transfer. The
// output channel o_out returns one labelled byte per input byte, in order:
// the byte itself, its kind, its argument number, argument and message end
// marks, and a status that reports a finished, oversized or malformed message or a closed stream.
// A byte is captured in an input register, labelled by the combinational
// parser, and held in an output register that offers the result on o_out.
// The parser state register is loaded together with the output register,
// so one byte per cycle is sustained while the receiver does not stall.
// When the receiver stalls, the output register holds its result and the
// input register can still take one more byte; after that i_in.ready drops
// until the receiver takes a transfer.
// A synchronous active-low reset empties both registers and returns the
// parser to the start of a frame length with the stream open. An oversized
// or malformed message closes the stream until the next reset.
module length_prefixed_request_deframer
    import lprd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    lprd_in_if.sink       i_in,
    lprd_out_if.source    o_out
);

    logic    in_valid;
    logic [7:0] in_byte;
    logic    out_free;
    logic    advance;
    t_state  r_state;
    t_state  n_state;
    t_result step_result;

    assign advance = in_valid && out_free;

    lprd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (advance),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    lprd_step u_step (
        .i_state  (r_state),
        .i_byte   (in_byte),
        .o_next   (n_state),
        .o_result (step_result)
    );

    lprd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (step_result),
        .o_free   (out_free),
        .o_out    (o_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase              <= PH_FRAME;
            r_state.field_byte_count   <= 2'd0;
            r_state.field_accumulator  <= 32'd0;
            r_state.message_bytes_left <= '0;
            r_state.args_left          <= '0;
            r_state.arg_bytes_left     <= '0;
            r_state.current_arg        <= '0;
            r_state.malformed          <= 1'b0;
            r_state.closed             <= 1'b0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    a_closed_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_state.closed) |=>
            (o_out.byte_kind == KIND_CLOSED && o_out.status == ST_CLOSED))
        else $error("Closed stream produced a result that is not marked closed.");

    a_end_has_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.message_end) |-> (o_out.status != ST_PROGRESS))
        else $error("Message end without a final status.");

    a_argn_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.byte_kind != KIND_LENGTH && o_out.byte_kind != KIND_DATA)
            |-> (o_out.arg_number == '0 && !o_out.arg_end))
        else $error("Argument fields set on a byte outside an argument.");

    a_inside_message: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_state.closed && r_state.phase != PH_FRAME) |-> (r_state.message_bytes_left != '0))
        else $error("Parser inside a message with no message bytes left.");

endmodule
